>>> hdl/cpr_pkg.sv
package cpr_pkg;

    localparam int unsigned CFG_IDX_BITS = 8;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_COUNT = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_POLICY_MODE = 8'd1;

    localparam int unsigned FAULT_BITS = 32;
    localparam int unsigned COUNT_BITS = 5;

endpackage

>>> hdl/clock_page_replacement.sv
// A hit or a fill passes through the lookup, write and output states; a replacement adds
// the victim scan, one frame per cycle, between the lookup and the write.
// Throughput: one access at a time; the next access is taken once the result register
// is free. The lookup walks the page memory one frame per cycle over its single read port.
// Reset: asynchronous, active low; clears valid/use/dirty bits, hand, fill and fault counts,
// and sets frame_count to 16 and policy_mode to basic clock. Page memory is not cleared.
module clock_page_replacement
    import cpr_pkg::*;
#(
    parameter int unsigned FRAMES    = 16,
    parameter int unsigned PAGE_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [PAGE_BITS-1:0] page_number, [PAGE_BITS] is_write, zero padded
    input  logic [((PAGE_BITS+1+7)/8)*8-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [0] hit, [4:1] frame_index, [5] evicted, [21:6] evicted_page, [53:22] fault_count
    output logic [55:0]             m_tdata,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COUNT_BITS-1:0]   cfg_data
);

    localparam int unsigned FB = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int unsigned NB = $clog2(FRAMES + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOK   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_WRITE  = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [PAGE_BITS-1:0] page_mem [FRAMES];
    logic [PAGE_BITS-1:0] rd_data_reg;
    logic [FB-1:0]        rd_addr;
    logic                 mem_we;
    logic [FB-1:0]        mem_waddr;

    logic [FRAMES-1:0] valid_reg, use_reg, dirty_reg;
    logic [FB-1:0]     hand_reg;
    logic [NB-1:0]     filled_reg;
    logic [FAULT_BITS-1:0] fault_reg;
    logic [COUNT_BITS-1:0] fcount_reg;
    logic              mode_reg;

    logic [2:0]        state_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic              wr_reg;
    logic [NB-1:0]     cnt_reg;      // frames issued in lookup
    logic              rd_pend_reg;  // read data of frame chk_reg valid
    logic [FB-1:0]     chk_reg;      // frame whose data is in rd_data_reg
    logic              hit_reg;
    logic [FB-1:0]     idx_reg;
    logic [FB-1:0]     scan_reg;
    logic [NB-1:0]     step_reg;
    logic [2:0]        pass_reg;
    logic              ev_reg;
    logic [FB-1:0]     hmod_reg;     // hand reduced below the active frame count
    logic [PAGE_BITS-1:0] ev_page_reg;
    logic [55:0]       out_reg;
    logic              out_valid_reg;

    logic [NB-1:0] n_act;
    always_comb
    begin
        if (fcount_reg == '0)
            n_act = NB'(1);
        else if (32'(fcount_reg) > FRAMES)
            n_act = NB'(FRAMES);
        else
            n_act = NB'(fcount_reg);
    end

    function automatic logic [FB-1:0] wrap_inc(input logic [FB-1:0] v, input logic [NB-1:0] n);
        logic [NB:0] s;
        begin
            s = (NB+1)'(v) + 1'b1;
            if (s >= (NB+1)'(n))
                s = '0;
            wrap_inc = s[FB-1:0];
        end
    endfunction

    assign s_tready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    // Lookup read address and memory write
    assign rd_addr   = cnt_reg[FB-1:0];
    assign mem_we    = (state_reg == ST_WRITE) && !hit_reg;
    assign mem_waddr = idx_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            page_mem[mem_waddr] <= page_reg;
        rd_data_reg <= page_mem[(state_reg == ST_SCAN) ? scan_reg : rd_addr];
    end

    logic cand_ok;
    logic [1:0] want;
    always_comb
    begin
        // scan: want bit 0 = dirty target, bit 1 = clear use while passing
        case (pass_reg)
            3'd0:    want = 2'b00;
            3'd1:    want = 2'b11;
            3'd2:    want = 2'b00;
            default: want = 2'b01;
        endcase
        if (!mode_reg)
            cand_ok = !use_reg[scan_reg];
        else
            cand_ok = !use_reg[scan_reg] && (dirty_reg[scan_reg] == want[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            use_reg       <= '0;
            dirty_reg     <= '0;
            hand_reg      <= '0;
            filled_reg    <= '0;
            fault_reg     <= '0;
            fcount_reg    <= COUNT_BITS'(16);
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            ev_reg        <= 1'b0;
            pass_reg      <= '0;
            step_reg      <= '0;
            idx_reg       <= '0;
            scan_reg      <= '0;
            chk_reg       <= '0;
            hmod_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FRAME_COUNT)
                    fcount_reg <= cfg_data;
                else if (cfg_index == REG_POLICY_MODE)
                    mode_reg <= cfg_data[0];
            end
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        page_reg    <= s_tdata[PAGE_BITS-1:0];
                        wr_reg      <= s_tdata[PAGE_BITS];
                        cnt_reg     <= '0;
                        rd_pend_reg <= 1'b0;
                        hit_reg     <= 1'b0;
                        ev_reg      <= 1'b0;
                        hmod_reg    <= hand_reg;
                        state_reg   <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    // The hand is brought below the frame count by one subtraction per
                    // cycle; the lookup lasts longer than the largest count of steps.
                    if (NB'(hmod_reg) >= n_act)
                        hmod_reg <= FB'(NB'(hmod_reg) - n_act);
                    // One frame read issued per cycle; compare the previous read.
                    if (rd_pend_reg && !hit_reg && valid_reg[chk_reg]
                        && NB'(chk_reg) < n_act && rd_data_reg == page_reg)
                    begin
                        hit_reg <= 1'b1;
                        idx_reg <= chk_reg;
                    end
                    if (cnt_reg < NB'(FRAMES))
                    begin
                        chk_reg     <= cnt_reg[FB-1:0];
                        rd_pend_reg <= 1'b1;
                        cnt_reg     <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        if (!rd_pend_reg)
                        begin
                            if (hit_reg)
                                state_reg <= ST_WRITE;
                            else if (filled_reg < n_act)
                            begin
                                idx_reg   <= filled_reg[FB-1:0];
                                state_reg <= ST_WRITE;
                            end
                            else
                            begin
                                scan_reg  <= hmod_reg;
                                step_reg  <= '0;
                                pass_reg  <= '0;
                                state_reg <= ST_SCAN;
                            end
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (cand_ok || pass_reg == 3'd4)
                    begin
                        idx_reg   <= (pass_reg == 3'd4) ? hmod_reg : scan_reg;
                        state_reg <= ST_WRITE;
                        ev_reg    <= 1'b1;
                    end
                    else
                    begin
                        if (!mode_reg || want[1])
                            use_reg[scan_reg] <= 1'b0;
                        scan_reg <= wrap_inc(scan_reg, n_act);
                        if (step_reg + 1'b1 >= n_act)
                        begin
                            step_reg <= '0;
                            pass_reg <= (!mode_reg && pass_reg == 3'd1) ? 3'd4
                                        : pass_reg + 1'b1;
                        end
                        else
                            step_reg <= step_reg + 1'b1;
                    end
                end
                ST_WRITE:
                begin
                    // Evicted page was read from the memory in the cycle before, during the scan.
                    if (hit_reg)
                    begin
                        use_reg[idx_reg] <= 1'b1;
                        if (wr_reg)
                            dirty_reg[idx_reg] <= 1'b1;
                    end
                    else
                    begin
                        valid_reg[idx_reg] <= 1'b1;
                        use_reg[idx_reg]   <= 1'b1;
                        dirty_reg[idx_reg] <= wr_reg;
                        if (!ev_reg)
                            filled_reg <= filled_reg + 1'b1;
                        else
                        begin
                            hand_reg <= wrap_inc(idx_reg, n_act);
                            if (fault_reg != '1)
                                fault_reg <= fault_reg + 1'b1;
                        end
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    out_reg[0]     <= hit_reg;
                    out_reg[4:1]   <= 4'(idx_reg);
                    out_reg[5]     <= ev_reg && valid_reg[idx_reg];
                    out_reg[21:6]  <= (ev_reg && valid_reg[idx_reg]) ?
                                      16'(ev_page_reg) : 16'd0;
                    out_reg[53:22] <= fault_reg;
                    out_reg[55:54] <= 2'b00;
                    out_valid_reg  <= 1'b1;
                    state_reg      <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Old page of the victim: captured from the read in the scan's final cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
            ev_page_reg <= rd_data_reg;
    end

endmodule

>>> test/clock_page_replacement_test.sv
`timescale 1ns / 100ps

module clock_page_replacement_test;
    import cpr_pkg::*;

    localparam int unsigned FRAMES    = 16;
    localparam int unsigned PAGE_BITS = 16;
    localparam int unsigned IN_W      = ((PAGE_BITS + 1 + 7) / 8) * 8;
    localparam int unsigned WATCHDOG  = 20000;

    typedef struct packed {
        logic [31:0] fault_count;
        logic [15:0] evicted_page;
        logic        evicted;
        logic [3:0]  frame_index;
        logic        hit;
    } access_result_t;

    typedef struct {
        logic [15:0]    page;
        logic           wr;
        logic           known;
        access_result_t want;
    } access_row_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [55:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [COUNT_BITS-1:0] cfg_data;

    clock_page_replacement #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS)) uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Shadow copy of the frame table.
    logic [15:0] mdl_page [FRAMES];
    logic        mdl_valid [FRAMES];
    logic        mdl_use [FRAMES];
    logic        mdl_dirty [FRAMES];
    int unsigned mdl_hand;
    int unsigned mdl_filled;
    logic [31:0] mdl_faults;
    int unsigned mdl_frame_count;
    logic        mdl_enhanced;

    access_result_t pending_results[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;
    bit hold_off;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic int scan_frames(int unsigned n, int unsigned hand, logic want_dirty,
                                       logic clear_use);
        int unsigned idx;
        for (int unsigned j = 0; j < n; j++)
        begin
            idx = (hand + j) % n;
            if (!mdl_use[idx] && mdl_dirty[idx] == want_dirty)
                return idx;
            if (clear_use)
                mdl_use[idx] = 1'b0;
        end
        return -1;
    endfunction

    function automatic int unsigned choose_victim(int unsigned n);
        int unsigned hand;
        int v;
        hand = mdl_hand % n;
        if (!mdl_enhanced)
        begin
            for (int unsigned j = 0; j < 2 * n; j++)
            begin
                if (!mdl_use[(hand + j) % n])
                    return (hand + j) % n;
                mdl_use[(hand + j) % n] = 1'b0;
            end
            return hand;
        end
        v = scan_frames(n, hand, 1'b0, 1'b0);
        if (v < 0)
            v = scan_frames(n, hand, 1'b1, 1'b1);
        if (v < 0)
            v = scan_frames(n, hand, 1'b0, 1'b0);
        if (v < 0)
            v = scan_frames(n, hand, 1'b1, 1'b0);
        if (v < 0)
            v = hand;
        return v;
    endfunction

    function automatic access_result_t predict_access(logic [15:0] page, logic wr);
        access_result_t r;
        int unsigned n;
        int unsigned idx;
        n = mdl_frame_count == 0 ? 1 : (mdl_frame_count > FRAMES ? FRAMES : mdl_frame_count);
        r = '0;
        idx = 0;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (mdl_valid[i] && mdl_page[i] == page)
            begin
                r.hit = 1'b1;
                idx = i;
                break;
            end
        end
        if (r.hit)
        begin
            mdl_use[idx] = 1'b1;
            if (wr)
                mdl_dirty[idx] = 1'b1;
        end
        else
        begin
            if (mdl_filled < n)
            begin
                idx = mdl_filled;
                mdl_filled++;
            end
            else
            begin
                idx = choose_victim(n);
                if (mdl_valid[idx])
                begin
                    r.evicted = 1'b1;
                    r.evicted_page = mdl_page[idx];
                end
                mdl_hand = (idx + 1) % n;
                if (mdl_faults != 32'hFFFF_FFFF)
                    mdl_faults++;
            end
            mdl_page[idx] = page;
            mdl_valid[idx] = 1'b1;
            mdl_use[idx] = 1'b1;
            mdl_dirty[idx] = wr;
        end
        r.frame_index = idx[3:0];
        r.fault_count = mdl_faults;
        return r;
    endfunction

    // The valid line is left high across a zero gap; wait_drained drops it after a batch.
    task automatic send_access(logic [15:0] page, logic wr);
        int gap;
        gap = $urandom_range(13);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_W - PAGE_BITS - 1){1'b0}}, wr, page};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        // An access still scanning could straddle a register write.
        repeat (5 * FRAMES + 10) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_BITS-1:0] index, logic [COUNT_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (index == REG_FRAME_COUNT)
            mdl_frame_count = value;
        else if (index == REG_POLICY_MODE)
            mdl_enhanced = value[0];
    endtask

    // Most pages are drawn from a small pool so that hits and evictions are frequent.
    task automatic random_accesses(int count, int unsigned pool);
        logic [15:0] page;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(19) == 0)
                page = 16'($urandom);
            else
                page = 16'($urandom_range(pool)) ^ 16'hA5C3;
            send_access(page, 1'($urandom_range(1)));
        end
    endtask

    // Accept side: prediction is made on input transfer, checking on output transfer.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            pending_results.push_back(predict_access(s_tdata[PAGE_BITS-1:0],
                                                     s_tdata[PAGE_BITS]));
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                access_result_t want;
                want = pending_results.pop_front();
                if (m_tdata[53:0] !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected hit %0d frame %0d ev %0d ",
                                  "page %h faults %0d, got hit %0d frame %0d ev %0d ",
                                  "page %h faults %0d"},
                                 want.hit, want.frame_index, want.evicted, want.evicted_page,
                                 want.fault_count, m_tdata[0], m_tdata[4:1], m_tdata[5],
                                 m_tdata[21:6], m_tdata[53:22]);
                end
            end
        end
    end

    // Receiver: random stalls, with one long hold-off on request.
    initial
    begin
        int stall;
        bit hold_done;
        hold_done = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                stall = ($urandom_range(3) == 0) ? 0 : $urandom_range(13);
                if (stall != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !timed_out)
        begin
            timed_out = 1'b1;
            $display("clock_page_replacement_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        access_row_t rows[$];
        access_row_t row;
        access_result_t got;
        int table_errors;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        table_errors = 0;
        hold_off = 1'b0;
        for (int i = 0; i < FRAMES; i++)
        begin
            mdl_page[i] = '0;
            mdl_valid[i] = 1'b0;
            mdl_use[i] = 1'b0;
            mdl_dirty[i] = 1'b0;
        end
        mdl_hand = 0;
        mdl_filled = 0;
        mdl_faults = '0;
        mdl_frame_count = 16;
        mdl_enhanced = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: the first rows after reset have results known by inspection.
        row = '{16'h0000, 1'b0, 1'b1, '{32'd0, 16'h0, 1'b0, 4'd0, 1'b0}};
        rows.push_back(row);
        row = '{16'hFFFF, 1'b1, 1'b1, '{32'd0, 16'h0, 1'b0, 4'd1, 1'b0}};
        rows.push_back(row);
        row = '{16'h0000, 1'b1, 1'b1, '{32'd0, 16'h0, 1'b0, 4'd0, 1'b1}};
        rows.push_back(row);
        row = '{16'hFFFF, 1'b0, 1'b1, '{32'd0, 16'h0, 1'b0, 4'd1, 1'b1}};
        rows.push_back(row);
        for (int i = 2; i < 18; i++)
        begin
            row = '{16'h5500 + i[15:0], i[0], 1'b0, '0};
            rows.push_back(row);
        end
        row = '{16'hAAAA, 1'b1, 1'b0, '0};
        rows.push_back(row);
        foreach (rows[i])
        begin
            got = predict_access(rows[i].page, rows[i].wr);
            if (rows[i].known && got !== rows[i].want)
            begin
                table_errors++;
                $display("table row %0d disagrees with predictor", i);
            end
        end
        // Rewind the shadow state and replay through the block.
        for (int i = 0; i < FRAMES; i++)
        begin
            mdl_valid[i] = 1'b0;
            mdl_use[i] = 1'b0;
            mdl_dirty[i] = 1'b0;
        end
        mdl_hand = 0;
        mdl_filled = 0;
        mdl_faults = '0;
        foreach (rows[i])
            send_access(rows[i].page, rows[i].wr);
        wait_drained();

        // Enhanced clock with one frame, then the full set, then a mid size.
        write_register(REG_POLICY_MODE, 5'd1);
        write_register(REG_FRAME_COUNT, 5'd1);
        random_accesses(150, 3);
        wait_drained();
        write_register(REG_FRAME_COUNT, 5'd0);
        write_register(REG_FRAME_COUNT, 5'd31);
        random_accesses(150, 24);
        wait_drained();
        write_register(REG_FRAME_COUNT, 5'd5);
        hold_off = 1'b1;
        random_accesses(300, 9);
        wait_drained();
        write_register(REG_POLICY_MODE, 5'd0);
        random_accesses(300, 9);
        wait_drained();
        write_register(REG_FRAME_COUNT, 5'd16);
        random_accesses(300, 22);
        wait_drained();
        write_register(REG_POLICY_MODE, 5'd1);
        write_register(REG_FRAME_COUNT, 5'd12);
        random_accesses(300, 18);
        wait_drained();

        if (mismatches == 0 && table_errors == 0 && pending_results.size() == 0)
            $display("clock_page_replacement_test OK");
        else
            $display("clock_page_replacement_test NOT OK");
        $finish;
    end

endmodule
